[rtl/lzwd_pkg.sv]
package lzwd_pkg;

  localparam int DICT_SIZE_DEF  = 4096;
  localparam int MAX_STRING_DEF = 64;
  localparam int LITERAL_COUNT  = 256;
  localparam int CODE_W         = 16;
  localparam int BYTE_W         = 8;
  // wide enough to compare a code against DICT_SIZE up to 65536
  localparam int CMP_W          = 17;

  typedef struct packed {
    logic              bad;
    logic              last;
    logic [BYTE_W-1:0] data;
  } out_item_t;

endpackage

[rtl/lzwd_dict.sv]
module lzwd_dict #(
  parameter int DICT_SIZE  = 4096,
  parameter int MAX_STRING = 64
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(DICT_SIZE)-1:0]        wr_addr,
  input  logic [$clog2(DICT_SIZE)-1:0]        wr_prefix,
  input  logic [lzwd_pkg::BYTE_W-1:0]         wr_suffix,
  input  logic [$clog2(MAX_STRING+2)-1:0]     wr_len,
  input  logic [$clog2(DICT_SIZE)-1:0]        rd_addr,
  output logic [$clog2(DICT_SIZE)-1:0]        rd_prefix,
  output logic [lzwd_pkg::BYTE_W-1:0]         rd_suffix,
  output logic [$clog2(MAX_STRING+2)-1:0]     rd_len
);
  import lzwd_pkg::*;

  localparam int CW = $clog2(DICT_SIZE);
  localparam int LW = $clog2(MAX_STRING + 2);
  localparam int EW = CW + BYTE_W + LW;

  // entry layout: {prefix, suffix, length}
  logic [EW-1:0] mem [DICT_SIZE];
  logic [EW-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_prefix, wr_suffix, wr_len};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_prefix = rd_q_r[EW-1 -: CW];
  assign rd_suffix = rd_q_r[LW +: BYTE_W];
  assign rd_len    = rd_q_r[LW-1:0];

endmodule

[rtl/lzwd_stack.sv]
module lzwd_stack #(
  parameter int MAX_STRING = 64
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_STRING)-1:0]   wr_addr,
  input  logic [lzwd_pkg::BYTE_W-1:0]     wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(MAX_STRING)-1:0]   rd_addr,
  output logic [lzwd_pkg::BYTE_W-1:0]     rd_data
);
  import lzwd_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_STRING];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/lzwd_outq.sv]
module lzwd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lzwd_pkg::out_item_t push_item,
  input  logic                pop,
  output logic [1:0]          cnt,
  output logic                head_valid,
  output lzwd_pkg::out_item_t head_item
);
  import lzwd_pkg::*;

  out_item_t slot_r [2];
  logic      wptr_r, wptr_nxt;
  logic      rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

  assign cnt        = cnt_r;
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = slot_r[rptr_r];

endmodule

[rtl/lzw_code_decoder.sv]
// Code decoder: one dictionary code in, its byte expansion out, last byte on tlast.
// A stored code passes S_LEN, S_WALK and S_EMIT; a literal skips S_LEN; the next free code
//   walks the previous code's chain; an error goes to S_ERR (via S_LEN for a bad stored length).
// A new code is taken only in S_IDLE, once the last stack read of the previous one is issued;
//   one dictionary read per walked byte, one stack read per byte.
// Reset (rst_n low, synchronous) clears control state, next free code (256) and output queue.
module lzw_code_decoder #(
  parameter int DICT_SIZE  = lzwd_pkg::DICT_SIZE_DEF,
  parameter int MAX_STRING = lzwd_pkg::MAX_STRING_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lzwd_pkg::CODE_W-1:0]   in_tdata,   // [15:0] code_word
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lzwd_pkg::BYTE_W-1:0]   out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,  // run_last
  output logic                          out_tuser   // [0] bad_code
);
  import lzwd_pkg::*;

  localparam int CW  = $clog2(DICT_SIZE);
  localparam int NFW = CW + 1;
  localparam int LW  = $clog2(MAX_STRING + 2);
  localparam int SW  = $clog2(MAX_STRING);

  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a code
  localparam logic [2:0] S_LEN  = 3'd1;  // length of a stored code is in the read register
  localparam logic [2:0] S_WALK = 3'd2;  // one prefix-chain step per cycle, filling the stack
  localparam logic [2:0] S_EMIT = 3'd3;  // read the stack front to back into the queue
  localparam logic [2:0] S_ERR  = 3'd4;  // queue one error result

  logic [2:0]        state_r, state_nxt;
  logic              seen_r, seen_nxt;
  logic [NFW-1:0]    nf_r, nf_nxt;             // next free code
  logic [CW-1:0]     prev_code_r, prev_code_nxt;
  logic [BYTE_W-1:0] prev_first_r, prev_first_nxt;
  logic [LW-1:0]     prev_len_r, prev_len_nxt;

  logic [CW-1:0]     cur_r, cur_nxt;           // chain node being walked
  logic [SW-1:0]     pos_r, pos_nxt;           // stack slot for cur's suffix
  logic [LW-1:0]     len_r, len_nxt;           // expansion length of this code
  logic [CW-1:0]     code_r, code_nxt;         // code of this transaction
  logic [SW-1:0]     idx_r, idx_nxt;           // emit index

  // one stack read (or error token) in flight toward the queue
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              pend_bad_r, pend_bad_nxt;

  // dictionary ports
  logic              dwr_en;
  logic [CW-1:0]     dwr_addr;
  logic [LW-1:0]     dwr_len;
  logic [CW-1:0]     drd_addr;
  logic [CW-1:0]     drd_prefix;
  logic [BYTE_W-1:0] drd_suffix;
  logic [LW-1:0]     drd_len;

  // stack ports
  logic              swr_en;
  logic [SW-1:0]     swr_addr;
  logic [BYTE_W-1:0] swr_data;
  logic              srd_en;
  logic [BYTE_W-1:0] srd_data;

  // queue
  logic              q_push, q_pop, q_valid;
  logic [1:0]        q_cnt;
  out_item_t         q_push_item, q_head;
  logic [2:0]        q_occ;
  logic              q_space;

  logic              in_acc;
  logic [CMP_W-1:0]  code_ext, nf_ext;
  logic              code_lit, cur_lit;
  logic [LW-1:0]     spec_len;
  logic [BYTE_W-1:0] sfx;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign q_pop     = out_tvalid && out_tready;

  // slots taken once this cycle's pop is done; a new read may go out if one is left
  assign q_occ   = 3'(q_cnt) + 3'(pend_r) - 3'(q_pop);
  assign q_space = (q_occ < 3'd2);

  assign code_ext = CMP_W'(in_tdata);
  assign nf_ext   = CMP_W'(nf_r);
  assign code_lit = (in_tdata[CODE_W-1:8] == '0);
  assign cur_lit  = (cur_r[CW-1:8] == '0);
  assign spec_len = prev_len_r + LW'(1);
  assign sfx      = cur_lit ? cur_r[BYTE_W-1:0] : drd_suffix;

  always_comb begin
    state_nxt      = state_r;
    seen_nxt       = seen_r;
    nf_nxt         = nf_r;
    prev_code_nxt  = prev_code_r;
    prev_first_nxt = prev_first_r;
    prev_len_nxt   = prev_len_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    code_nxt       = code_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_last_nxt  = pend_last_r;
    pend_bad_nxt   = pend_bad_r;

    dwr_en   = 1'b0;
    dwr_addr = nf_r[CW-1:0];
    dwr_len  = prev_len_r + LW'(1);
    drd_addr = cur_r;
    swr_en   = 1'b0;
    swr_addr = pos_r;
    swr_data = sfx;
    srd_en   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          code_nxt = in_tdata[CW-1:0];
          cur_nxt  = in_tdata[CW-1:0];
          drd_addr = in_tdata[CW-1:0];
          pos_nxt  = '0;
          len_nxt  = LW'(1);
          priority if (!seen_r) begin
            // first code after reset must be a literal
            state_nxt = code_lit ? S_WALK : S_ERR;
          end else if (code_ext >= CMP_W'(DICT_SIZE) || code_ext > nf_ext) begin
            state_nxt = S_ERR;
          end else if (code_ext == nf_ext) begin
            // code not yet stored: previous string plus its own first byte
            if (spec_len > LW'(MAX_STRING)) begin
              state_nxt = S_ERR;
            end else begin
              swr_en    = 1'b1;
              swr_addr  = SW'(prev_len_r);
              swr_data  = prev_first_r;
              cur_nxt   = prev_code_r;
              drd_addr  = prev_code_r;
              pos_nxt   = SW'(prev_len_r - LW'(1));
              len_nxt   = spec_len;
              state_nxt = S_WALK;
            end
          end else if (code_lit) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_LEN;
          end
        end
      end

      S_LEN: begin
        if (drd_len == '0 || drd_len > LW'(MAX_STRING)) begin
          state_nxt = S_ERR;
        end else begin
          len_nxt   = drd_len;
          pos_nxt   = SW'(drd_len - LW'(1));
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        swr_en = 1'b1;
        if (pos_r == '0) begin
          // sfx is the first byte of the expansion: commit the step
          if (seen_r && nf_r < NFW'(DICT_SIZE)) begin
            dwr_en = 1'b1;
            nf_nxt = nf_r + NFW'(1);
          end
          seen_nxt       = 1'b1;
          prev_code_nxt  = code_r;
          prev_first_nxt = sfx;
          prev_len_nxt   = len_r;
          idx_nxt        = '0;
          state_nxt      = S_EMIT;
        end else begin
          cur_nxt  = drd_prefix;
          drd_addr = drd_prefix;
          pos_nxt  = pos_r - SW'(1);
        end
      end

      S_EMIT: begin
        if (q_space) begin
          srd_en        = 1'b1;
          pend_nxt      = 1'b1;
          pend_bad_nxt  = 1'b0;
          pend_last_nxt = (LW'(idx_r) == len_r - LW'(1));
          idx_nxt       = idx_r + SW'(1);
          if (pend_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_ERR: begin
        if (q_space) begin
          pend_nxt      = 1'b1;
          pend_bad_nxt  = 1'b1;
          pend_last_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seen_r       <= 1'b0;
      nf_r         <= NFW'(LITERAL_COUNT);
      prev_code_r  <= '0;
      prev_first_r <= '0;
      prev_len_r   <= '0;
      pend_r       <= 1'b0;
      pend_bad_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seen_r       <= seen_nxt;
      nf_r         <= nf_nxt;
      prev_code_r  <= prev_code_nxt;
      prev_first_r <= prev_first_nxt;
      prev_len_r   <= prev_len_nxt;
      pend_r       <= pend_nxt;
      pend_bad_r   <= pend_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    pos_r       <= pos_nxt;
    len_r       <= len_nxt;
    code_r      <= code_nxt;
    idx_r       <= idx_nxt;
    pend_last_r <= pend_last_nxt;
  end

  // in-flight read is pushed into the queue in the cycle after issue
  assign q_push = pend_r;
  always_comb begin
    if (pend_bad_r) begin
      q_push_item = '{bad: 1'b1, last: 1'b1, data: '0};
    end else begin
      q_push_item = '{bad: 1'b0, last: pend_last_r, data: srd_data};
    end
  end

  lzwd_dict #(
    .DICT_SIZE  (DICT_SIZE),
    .MAX_STRING (MAX_STRING)
  ) u_dict (
    .clk       (clk),
    .wr_en     (dwr_en),
    .wr_addr   (dwr_addr),
    .wr_prefix (prev_code_r),
    .wr_suffix (sfx),
    .wr_len    (dwr_len),
    .rd_addr   (drd_addr),
    .rd_prefix (drd_prefix),
    .rd_suffix (drd_suffix),
    .rd_len    (drd_len)
  );

  lzwd_stack #(
    .MAX_STRING (MAX_STRING)
  ) u_stack (
    .clk     (clk),
    .wr_en   (swr_en),
    .wr_addr (swr_addr),
    .wr_data (swr_data),
    .rd_en   (srd_en),
    .rd_addr (idx_r),
    .rd_data (srd_data)
  );

  lzwd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .pop        (q_pop),
    .cnt        (q_cnt),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  assign out_tvalid = q_valid;
  assign out_tdata  = q_head.data;
  assign out_tlast  = q_head.last;
  assign out_tuser  = q_head.bad;

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_cnt < 2'd2 || q_pop))
    else $error("output queue overflow");

  // next free code never exceeds DICT_SIZE
  a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= NFW'(DICT_SIZE))
    else $error("next free code out of range");

  // each dictionary write advances the next free code by one
  a_nf_step: assert property (@(posedge clk) disable iff (!rst_n)
    dwr_en |=> (nf_r == $past(nf_r) + NFW'(1)))
    else $error("dictionary write without next free code advance");

  // an error token is always a one-result run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && pend_bad_r) |-> q_push_item.last)
    else $error("error result not marked last");

  // no new code is taken while the stack is being read out
  a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    srd_en |-> !in_acc)
    else $error("code accepted during emit");

endmodule
